// File: sv/rslf_pkg.sv
`timescale 1ns / 1ps

package rslf_pkg;

    localparam int MAX_SIDE   = 4096;
    localparam int LUMA_BITS  = 16;

    localparam int COORD_W    = $clog2(MAX_SIDE);
    localparam int REG_W      = COORD_W + 1;
    localparam int LUMA_W     = LUMA_BITS;
    localparam int CFG_IDX_W  = 8;

    // falloff radius and its derived widths
    localparam int RADIUS     = 200;
    localparam int DIST_W     = 8;
    localparam int SQ_W       = 2 * DIST_W;
    localparam int SUMSQ_W    = SQ_W + 1;
    localparam int SQRT_STEPS = DIST_W;
    localparam int SQRT_REM_W = DIST_W + 1;
    localparam int SQRT_SH_W  = SQRT_REM_W + 2;
    localparam int PROD_W     = LUMA_W + DIST_W;

    // first sum of squares whose floored root exceeds the radius
    localparam logic [SUMSQ_W-1:0] SUMSQ_LIMIT = SUMSQ_W'((RADIUS + 1) * (RADIUS + 1));

    // floor(p / 200) = floor(floor(p / 8) / 25), the latter by reciprocal
    localparam int DIV_SHIFT  = 3;
    localparam int DIV_REST   = RADIUS / 8;
    localparam int QUOT_W     = PROD_W - DIV_SHIFT;
    localparam int RECIP_SH   = 26;
    localparam int RECIP_W    = 22;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'((64'd1 << RECIP_SH) / DIV_REST);
    localparam int RPROD_W    = QUOT_W + RECIP_W;
    localparam int EST_W      = RPROD_W - RECIP_SH;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(3);

    typedef struct packed {
        logic [REG_W-1:0] center_x;
        logic [REG_W-1:0] center_y;
        logic [REG_W-1:0] image_width;
        logic [REG_W-1:0] image_height;
    } t_cfg;

    // classified pixel handed from front to back
    typedef struct packed {
        logic              invalid;
        logic              far;
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
        logic [LUMA_W-1:0] luma;
    } t_item;

endpackage

// File: sv/radial_spotlight_luma_falloff.sv
`timescale 1ns / 1ps

// Radial spotlight falloff: each pixel's luminance is scaled by (200 - d) / 200, floored,
// where d is the floored Euclidean distance to the configured center; pixels 200 or more
// away come out black. A center beyond the image size passes luminance through and sets
// the tuser flag. One pixel is taken and one result given per clock when the output is
// not stalled. Between an input beat and its output beat there lie one classify register,
// one queue slot, then a 14-stage back pipeline (squares, sum, eight root stages, scale
// multiply, reciprocal multiply for the divide by 200, correction and output register).
// A four-deep queue between classify and the back pipeline absorbs stalls on either side.
// Configuration should be written only while no pixel is in flight.

module radial_spotlight_luma_falloff (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [39:0]                    i_s_tdata,   // pixel_col, pixel_row, luma_in
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [15:0]                    o_m_tdata,   // luma_out
    output logic                           o_m_tuser,   // center_invalid
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rslf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rslf_pkg::REG_W-1:0]     i_cfg_data
);
    import rslf_pkg::*;

    t_cfg              r_cfg;
    logic              w_fe_push;
    t_item             w_fe_item;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_q_pop;
    t_item             w_q_item;
    logic [LUMA_W-1:0] w_luma;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x     <= '0;
            r_cfg.center_y     <= '0;
            r_cfg.image_width  <= REG_W'(MAX_SIDE);
            r_cfg.image_height <= REG_W'(MAX_SIDE);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CENTER_X:     r_cfg.center_x     <= i_cfg_data;
                REG_CENTER_Y:     r_cfg.center_y     <= i_cfg_data;
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rslf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_col   (i_s_tdata[COORD_W-1:0]),
        .i_row   (i_s_tdata[2*COORD_W-1:COORD_W]),
        .i_luma  (i_s_tdata[2*COORD_W+LUMA_W-1:2*COORD_W]),
        .o_push  (w_fe_push),
        .i_full  (w_q_full),
        .o_item  (w_fe_item)
    );

    rslf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fe_push),
        .i_data  (w_fe_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_item)
    );

    rslf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_q_empty),
        .i_item    (w_q_item),
        .o_pop     (w_q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_luma    (w_luma),
        .o_invalid (o_m_tuser)
    );

    assign o_m_tdata = w_luma;

    // back pipeline only pulls when the queue holds a beat
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("queue popped while empty");

    // classify register keeps its beat while the queue is full
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fe_push && w_q_full) |=> w_fe_push)
        else $error("front dropped a beat on a full queue");

    // a full queue with a beat held in the classify register must back-pressure the input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fe_push && w_q_full) |-> !o_s_tready)
        else $error("input accepted while queue full and front busy");

endmodule

// File: sv/rslf_front.sv
`timescale 1ns / 1ps

module rslf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rslf_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rslf_pkg::COORD_W-1:0] i_col,
    input  logic [rslf_pkg::COORD_W-1:0] i_row,
    input  logic [rslf_pkg::LUMA_W-1:0]  i_luma,
    output logic                         o_push,
    input  logic                         i_full,
    output rslf_pkg::t_item              o_item
);
    import rslf_pkg::*;

    logic             r_vld;
    t_item            r_item;
    t_item            n_item;
    logic [REG_W-1:0] w_wlim;
    logic [REG_W-1:0] w_hlim;
    logic [REG_W-1:0] w_col;
    logic [REG_W-1:0] w_row;
    logic [REG_W-1:0] w_dx;
    logic [REG_W-1:0] w_dy;

    always_comb begin
        w_wlim = (i_cfg.image_width > REG_W'(MAX_SIDE)) ? REG_W'(MAX_SIDE) : i_cfg.image_width;
        w_hlim = (i_cfg.image_height > REG_W'(MAX_SIDE)) ? REG_W'(MAX_SIDE) : i_cfg.image_height;
        w_col  = {1'b0, i_col};
        w_row  = {1'b0, i_row};
        w_dx   = (w_col > i_cfg.center_x) ? w_col - i_cfg.center_x : i_cfg.center_x - w_col;
        w_dy   = (w_row > i_cfg.center_y) ? w_row - i_cfg.center_y : i_cfg.center_y - w_row;
        n_item.invalid = (i_cfg.center_x > w_wlim) || (i_cfg.center_y > w_hlim);
        n_item.far     = (w_dx > REG_W'(RADIUS)) || (w_dy > REG_W'(RADIUS));
        n_item.dx      = w_dx[DIST_W-1:0];
        n_item.dy      = w_dy[DIST_W-1:0];
        n_item.luma    = i_luma;
    end

    assign o_ready = !r_vld || !i_full;
    assign o_push  = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// File: sv/rslf_queue.sv
`timescale 1ns / 1ps

module rslf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rslf_pkg::t_item i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output rslf_pkg::t_item o_data
);
    import rslf_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_cnt;
    logic               w_wen;
    logic               w_ren;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wen   = i_push && !o_full;
    assign w_ren   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wen) r_wr <= r_wr + 1'b1;
            if (w_ren) r_rd <= r_rd + 1'b1;
            if (w_wen && !w_ren) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_ren && !w_wen) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/rslf_back.sv
`timescale 1ns / 1ps

module rslf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  rslf_pkg::t_item             i_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rslf_pkg::LUMA_W-1:0] o_luma,
    output logic                        o_invalid
);
    import rslf_pkg::*;

    // squares, sum, root steps, scale multiply, reciprocal multiply, correct, output
    localparam int NSTG = SQRT_STEPS + 6;

    logic [NSTG-1:0]       r_vld;
    logic                  w_ce;

    // squares
    logic [SQ_W-1:0]       r_sqx;
    logic [SQ_W-1:0]       r_sqy;
    logic                  r1_far;
    logic                  r1_inv;
    logic [LUMA_W-1:0]     r1_luma;
    logic [SUMSQ_W-1:0]    w_sum;

    // root pipeline, entry 0 is the sum stage
    logic [SQ_W-1:0]       r_rad  [SQRT_STEPS+1];
    logic [SQRT_REM_W-1:0] r_rem  [SQRT_STEPS+1];
    logic [DIST_W-1:0]     r_root [SQRT_STEPS+1];
    logic                  r_ovr  [SQRT_STEPS+1];
    logic                  r_inv  [SQRT_STEPS+1];
    logic [LUMA_W-1:0]     r_luma [SQRT_STEPS+1];

    // scale and divide
    logic [DIST_W-1:0]     w_fac;
    logic [PROD_W-1:0]     r_prod;
    logic                  rm_inv;
    logic [LUMA_W-1:0]     rm_luma;
    logic [QUOT_W-1:0]     w_quot;
    logic [RPROD_W-1:0]    r_rprod;
    logic [QUOT_W-1:0]     rr_quot;
    logic                  rr_inv;
    logic [LUMA_W-1:0]     rr_luma;
    logic [EST_W-1:0]      r_est;
    logic [QUOT_W-1:0]     re_quot;
    logic                  re_inv;
    logic [LUMA_W-1:0]     re_luma;
    logic [QUOT_W:0]       w_back;
    logic [QUOT_W:0]       w_diff;
    logic [EST_W-1:0]      w_res;

    logic                  r_out_inv;
    logic [LUMA_W-1:0]     r_out_luma;

    assign w_ce      = !r_vld[NSTG-1] || i_ready;
    assign o_pop     = w_ce && !i_empty;
    assign o_valid   = r_vld[NSTG-1];
    assign o_luma    = r_out_luma;
    assign o_invalid = r_out_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[NSTG-2:0], !i_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sqx   <= i_item.dx * i_item.dx;
            r_sqy   <= i_item.dy * i_item.dy;
            r1_far  <= i_item.far;
            r1_inv  <= i_item.invalid;
            r1_luma <= i_item.luma;
        end
    end

    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_rad[0]  <= w_sum[SQ_W-1:0];
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_ovr[0]  <= r1_far || (w_sum >= SUMSQ_LIMIT);
            r_inv[0]  <= r1_inv;
            r_luma[0] <= r1_luma;
        end
    end

    // restoring square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam int LO = 2 * (SQRT_STEPS - 1 - k);
        logic [SQRT_SH_W-1:0] w_sh;
        logic [SQRT_SH_W-1:0] w_trial;
        logic [SQRT_SH_W-1:0] w_sub;
        logic                 w_ge;

        always_comb begin
            w_sh    = {r_rem[k], r_rad[k][LO+1:LO]};
            w_trial = {1'b0, r_root[k], 2'b01};
            w_sub   = w_sh - w_trial;
            w_ge    = (w_sh >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_rad[k+1]  <= r_rad[k];
                r_rem[k+1]  <= w_ge ? w_sub[SQRT_REM_W-1:0] : w_sh[SQRT_REM_W-1:0];
                r_root[k+1] <= {r_root[k][DIST_W-2:0], w_ge};
                r_ovr[k+1]  <= r_ovr[k];
                r_inv[k+1]  <= r_inv[k];
                r_luma[k+1] <= r_luma[k];
            end
        end
    end

    assign w_fac = r_ovr[SQRT_STEPS] ? '0 : DIST_W'(RADIUS) - r_root[SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_prod  <= PROD_W'(r_luma[SQRT_STEPS] * w_fac);
            rm_inv  <= r_inv[SQRT_STEPS];
            rm_luma <= r_luma[SQRT_STEPS];
        end
    end

    assign w_quot = r_prod[PROD_W-1:DIV_SHIFT];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_rprod <= RPROD_W'(w_quot * RECIP_MUL);
            rr_quot <= w_quot;
            rr_inv  <= rm_inv;
            rr_luma <= rm_luma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_est   <= r_rprod[RPROD_W-1:RECIP_SH];
            re_quot <= rr_quot;
            re_inv  <= rr_inv;
            re_luma <= rr_luma;
        end
    end

    // estimate is exact or one low
    always_comb begin
        w_back = (QUOT_W+1)'(r_est * DIV_REST);
        w_diff = {1'b0, re_quot} - w_back;
        w_res  = (w_diff >= (QUOT_W+1)'(DIV_REST)) ? r_est + 1'b1 : r_est;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_inv  <= re_inv;
            r_out_luma <= re_inv ? re_luma : w_res[LUMA_W-1:0];
        end
    end

endmodule
